// ===== hdl/mavg_pkg.sv =====
// shared types and constants for the moving average with warm-up
`timescale 1ns / 1ps
`default_nettype none
package mavg_pkg;

  localparam int unsigned WINDOW   = 8;
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned SUM_W    = 16;
  localparam int unsigned FILL_W   = (WINDOW > 2) ? $clog2(WINDOW) : 1;
  localparam int unsigned TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;

  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WINDOW - 1);

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [FILL_W-1:0]   fill_t;

endpackage
`default_nettype wire

// ===== hdl/mavg_cell.sv =====
// one cell of the sample line: holds a sample and passes it on each beat
`timescale 1ns / 1ps
`default_nettype none
module mavg_cell (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     shift_i,
  input  wire mavg_pkg::sample_t  data_i,
  output mavg_pkg::sample_t       data_o
);
  import mavg_pkg::*;

  sample_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (shift_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

// ===== hdl/moving_average_warmup.sv =====
// moving average with warm-up pass-through, built on a line of sample cells
// each input beat's result is on the output register in the cycle after the beat is accepted
// throughput: one beat per cycle while the output is not stalled; the line shifts and
//   the running sum update in the same cycle, and the output register is refilled as it drains
// reset: asynchronous active low; all cells, the sum and the fill count clear
//   to zero, no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none
module moving_average_warmup (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire  [mavg_pkg::TDATA_W-1:0]       s_axis_tdata,  // [9:0] sample, rest ignored
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic [mavg_pkg::TDATA_W-1:0]       m_axis_tdata,  // [9:0] filtered, rest zero
  output logic                               m_axis_tuser   // [0] is_average
);
  import mavg_pkg::*;

  logic    accept;
  sample_t sample;
  sample_t tap [WINDOW+1];

  sum_t    sum_q, sum_d;
  fill_t   fill_q, fill_d;
  logic    warm_done;

  logic    valid_q;
  sample_t filtered_q, filtered_d;
  logic    avg_q;
  sum_t    quot;

  assign s_axis_tready = !valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign sample        = s_axis_tdata[SAMPLE_W-1:0];

  // newest sample enters cell 0, the oldest leaves from the last cell
  assign tap[0] = sample;
  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    mavg_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (accept),
      .data_i  (tap[k]),
      .data_o  (tap[k+1])
    );
  end

  assign warm_done = (fill_q == FILL_LAST);

  always_comb begin
    sum_d  = sum_q - SUM_W'(tap[WINDOW]) + SUM_W'(sample);
    fill_d = warm_done ? fill_q : fill_q + fill_t'(1);
    quot   = sum_d / SUM_W'(WINDOW);
    filtered_d = warm_done ? quot[SAMPLE_W-1:0] : sample;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      fill_q <= '0;
    end else if (accept) begin
      sum_q  <= sum_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      filtered_q <= filtered_d;
      avg_q      <= warm_done;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {{(TDATA_W-SAMPLE_W){1'b0}}, filtered_q};
  assign m_axis_tuser  = avg_q;

endmodule
`default_nettype wire

// ===== verif/tb_moving_average_warmup.sv =====
// self-checking testbench for the moving average with warm-up pass-through
`timescale 1ns / 1ps
module tb_moving_average_warmup;
  import mavg_pkg::*;

  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned PHASE_BEATS = 300;

  typedef struct packed {
    sample_t filtered;
    logic    is_average;
  } filt_result_t;

  typedef struct {
    logic [TDATA_W-1:0] data;
    int unsigned        gap_pct;
    int unsigned        stall_pct;
    bit                 drain;
  } sample_plan_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  wire                s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;   // [9:0] sample, rest ignored
  wire                m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  wire  [TDATA_W-1:0] m_axis_tdata;        // [9:0] filtered, rest zero
  wire                m_axis_tuser;        // [0] is_average

  moving_average_warmup u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // filter state mirrored on the testbench side
  sample_t      avg_store [WINDOW];
  fill_t        avg_widx = '0;
  logic [6:0]   avg_fill = '0;
  sum_t         avg_sum = '0;

  sample_plan_t plan_q[$];
  filt_result_t expected_filtered_q[$];
  logic         in_fire = 1'b0;
  int unsigned  stall_pct = 0;
  int unsigned  error_count = 0;
  int unsigned  idle_cycles = 0;

  initial begin
    for (int i = 0; i < WINDOW; i++) avg_store[i] = '0;
  end

  function automatic filt_result_t predict_filtered(sample_t s);
    filt_result_t r;
    avg_sum = avg_sum - sum_t'(avg_store[avg_widx]) + sum_t'(s);
    avg_store[avg_widx] = s;
    avg_widx = (avg_widx == fill_t'(WINDOW - 1)) ? '0 : avg_widx + 1'b1;
    if (avg_fill < 7'(WINDOW - 1)) begin
      avg_fill = avg_fill + 1'b1;
      r.filtered = s;
      r.is_average = 1'b0;
    end else begin
      r.filtered = sample_t'(avg_sum / sum_t'(WINDOW));
      r.is_average = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic logic [TDATA_W-1:0] random_sample();
    logic [TDATA_W-1:0] d;
    d = '0;
    case ($urandom_range(0, 9))
      0:       d[SAMPLE_W-1:0] = '0;
      1:       d[SAMPLE_W-1:0] = '1;
      2:       d[SAMPLE_W-1:0] = sample_t'($urandom_range(0, 15));
      3:       d[SAMPLE_W-1:0] = sample_t'($urandom_range(1008, 1023));
      default: d[SAMPLE_W-1:0] = sample_t'($urandom_range(0, 1023));
    endcase
    return d;
  endfunction

  // input and output beats, prediction and checking
  always @(posedge clk_i) begin
    filt_result_t got;
    filt_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.filtered = m_axis_tdata[SAMPLE_W-1:0];
        got.is_average = m_axis_tuser;
        if (expected_filtered_q.size() == 0) begin
          report_mismatch("unexpected beat, filtered", got.filtered, -1);
        end else begin
          want = expected_filtered_q.pop_front();
          if (got.filtered !== want.filtered)
            report_mismatch("filtered", got.filtered, want.filtered);
          if (got.is_average !== want.is_average)
            report_mismatch("is_average", got.is_average, want.is_average);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_filtered_q.push_back(predict_filtered(s_axis_tdata[SAMPLE_W-1:0]));
    end
    in_fire <= rst_ni && s_axis_tvalid && s_axis_tready;
  end

  // sender
  always @(negedge clk_i) begin
    logic               nv;
    logic [TDATA_W-1:0] nd;
    bit                 take;
    nv = s_axis_tvalid;
    nd = s_axis_tdata;
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      nv = 1'b0;
      if (plan_q.size() != 0) begin
        take = 1'b1;
        // hold off until the filter has nothing left in flight
        if (plan_q[0].drain && expected_filtered_q.size() != 0) take = 1'b0;
        if (take && $urandom_range(1, 100) <= plan_q[0].gap_pct) take = 1'b0;
        if (take) begin
          nv = 1'b1;
          nd = plan_q[0].data;
          stall_pct <= plan_q[0].stall_pct;
          void'(plan_q.pop_front());
        end
      end
    end
    s_axis_tvalid <= nv;
    s_axis_tdata <= nd;
  end

  // receiver
  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && ($urandom_range(1, 100) > stall_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_moving_average_warmup: done, errors");
      $finish;
    end
  end

  initial begin
    sample_plan_t p;
    logic [TDATA_W-1:0] directed [$];
    int unsigned gap_tab [4];
    int unsigned stall_tab [4];
    gap_tab = '{0, 57, 0, 31};
    stall_tab = '{0, 0, 57, 31};

    // warm-up pass-through: extremes, alternating bits, junk above the sample
    directed = {16'h0000, 16'h03FF, 16'h02AA, 16'h0155, 16'hFC01, 16'hA800 | 16'h0200,
                16'h03FF};
    // first averaged beat, then a window full of top-scale samples
    for (int i = 0; i < 8; i++) directed.push_back(i == 3 ? 16'h57FF : 16'h03FF);
    // a window of zeros
    for (int i = 0; i < 8; i++) directed.push_back(16'h0000);
    foreach (directed[i]) begin
      p.data = directed[i];
      p.gap_pct = 0;
      p.stall_pct = 0;
      p.drain = 1'b0;
      plan_q.push_back(p);
    end
    for (int ph = 0; ph < 4; ph++) begin
      for (int i = 0; i < PHASE_BEATS; i++) begin
        p.data = random_sample();
        p.gap_pct = gap_tab[ph];
        p.stall_pct = stall_tab[ph];
        p.drain = (i == 0) || (i == PHASE_BEATS / 2);
        plan_q.push_back(p);
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (plan_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_filtered_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_moving_average_warmup: done, clean");
    end else begin
      $display("tb_moving_average_warmup: done, errors");
    end
    $finish;
  end

endmodule
